### rtl/core/ffsi_pkg.sv
package ffsi_pkg;

    // edges are brought below 2^17, normal components below 2^20
    localparam int ESIG_BITS = 17;
    localparam int EDGE_W    = ESIG_BITS + 1;
    localparam int NORM_W    = 2 * EDGE_W;
    localparam int NSIG_BITS = 20;
    localparam int NP_W      = NSIG_BITS + 1;
    localparam int SUM_W     = NP_W + 2;
    localparam int SQ_W      = 2 * NP_W;
    localparam int Q_W       = SQ_W;
    localparam int T_W       = Q_W + 2;
    localparam int SSQ_W     = 2 * (SUM_W - 1);

    localparam int OUT_W = 16;
    localparam logic [OUT_W-1:0] OUT_MAX     = 16'hFFFF;
    localparam logic [OUT_W-1:0] FLOOR_RESET = 16'd328;

    localparam int QUEUE_DEPTH = 4;

    // one classified face waiting for the divide and root
    typedef struct packed {
        logic [SSQ_W-1:0] s_sq;
        logic [T_W-1:0]   t3q;
        logic             zero_n;
        logic             lit;
    } front_item_t;

endpackage

### rtl/core/ffsi_if.sv
interface ffsi_tri_if #(parameter int COORD_WIDTH = 16) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] a_x;
    logic signed [COORD_WIDTH-1:0] a_y;
    logic signed [COORD_WIDTH-1:0] a_z;
    logic signed [COORD_WIDTH-1:0] b_x;
    logic signed [COORD_WIDTH-1:0] b_y;
    logic signed [COORD_WIDTH-1:0] b_z;
    logic signed [COORD_WIDTH-1:0] c_x;
    logic signed [COORD_WIDTH-1:0] c_y;
    logic signed [COORD_WIDTH-1:0] c_z;

    modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                    input ready);
    modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                  output ready);
endinterface

interface ffsi_shade_if ();
    import ffsi_pkg::*;
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] intensity;
    logic             degenerate;

    modport source (output valid, intensity, degenerate, input ready);
    modport sink (input valid, intensity, degenerate, output ready);
endinterface

### rtl/core/face_flat_shading_intensity.sv
// flat lambert shading of one triangle per item
// face channel (valid/ready): nine signed vertex coordinates a, b, c
// shade channel (valid/ready): intensity in unsigned q1.15 and a degenerate flag
// cfg_wr_en / cfg_wr_data: writes the ambient floor, read as each item leaves the back
// one item per cycle sustained while shade is ready, triangles are fully independent
// the back pipeline holds the restoring divide (one quotient bit per stage)
// and the square root (one root bit per stage)
// the front pipeline forms edges, normal and classifies the face, then parks it
// in a four-entry queue; a stalled receiver first stops the back, the queue
// fills, then the front stops and face.ready drops
// reset empties both pipelines and the queue and sets the floor to 328
module face_flat_shading_intensity #(
    parameter int COORD_WIDTH         = 16,
    parameter int INTENSITY_FRAC_BITS = 15
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [ffsi_pkg::OUT_W-1:0] cfg_wr_data,
    ffsi_tri_if.sink                   face,
    ffsi_shade_if.source               shade
);
    import ffsi_pkg::*;

    // ambient floor register
    logic [OUT_W-1:0] floor_reg, floor_next;

    // queue hookup between front and back
    front_item_t push_item, pop_item;
    logic        q_push, q_pop, q_full, q_empty;

    assign floor_next = cfg_wr_en ? cfg_wr_data : floor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            floor_reg <= FLOOR_RESET;
        else
            floor_reg <= floor_next;
    end

    // edges, normal, normalizing shifts, sum and squares, then classification
    ffsi_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .face   (face),
        .q_full (q_full),
        .q_push (q_push),
        .q_item (push_item)
    );

    // lets front and back stall apart
    ffsi_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (pop_item),
        .empty     (q_empty)
    );

    // divide, square root, floor and output register
    ffsi_back #(
        .INTENSITY_FRAC_BITS (INTENSITY_FRAC_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_item        (pop_item),
        .q_pop         (q_pop),
        .ambient_floor (floor_reg),
        .shade         (shade)
    );

endmodule

### rtl/core/ffsi_front.sv
module ffsi_front #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    ffsi_tri_if.sink              face,
    input  logic                  q_full,
    output logic                  q_push,
    output ffsi_pkg::front_item_t q_item
);
    import ffsi_pkg::*;

    localparam int EW     = COORD_WIDTH + 1;
    localparam int EKW    = $clog2(EW + 1);
    localparam int NKW    = $clog2(NORM_W + 1);
    localparam int STAGES = 10;

    function automatic logic [EW-1:0] emag_f(logic signed [EW-1:0] v);
        return v[EW-1] ? $unsigned(-v) : $unsigned(v);
    endfunction

    function automatic logic [NORM_W-1:0] nmag_f(logic signed [NORM_W-1:0] v);
        return v[NORM_W-1] ? $unsigned(-v) : $unsigned(v);
    endfunction

    logic              adv;
    logic [STAGES-1:0] vld_reg, vld_next;

    logic signed [EW-1:0]     e1_reg [6], e1_next [6];
    logic signed [EW-1:0]     e2_reg [6], e2_next [6];
    logic [EKW-1:0]           ek_reg, ek_next;
    logic signed [EDGE_W-1:0] e3_reg [6], e3_next [6];
    logic signed [NORM_W-1:0] p4_reg [6], p4_next [6];
    logic signed [NORM_W-1:0] n5_reg [3], n5_next [3];
    logic                     z5_reg, z5_next;
    logic signed [NORM_W-1:0] n6_reg [3], n6_next [3];
    logic [NKW-1:0]           nk_reg, nk_next;
    logic                     z6_reg, z6_next;
    logic signed [NP_W-1:0]   n7_reg [3], n7_next [3];
    logic                     z7_reg, z7_next;
    logic signed [SUM_W-1:0]  s8_reg, s8_next;
    logic [SQ_W-1:0]          sq8_reg [3], sq8_next [3];
    logic                     z8_reg, z8_next;
    logic [Q_W-1:0]           q9_reg, q9_next;
    logic [SSQ_W-1:0]         ssq9_reg, ssq9_next;
    logic                     lit9_reg, lit9_next;
    logic                     z9_reg, z9_next;
    logic [T_W-1:0]           t10_reg, t10_next;
    logic [SSQ_W-1:0]         ssq10_reg, ssq10_next;
    logic                     lit10_reg, lit10_next;
    logic                     z10_reg, z10_next;

    logic [EW-1:0]            emag [6];
    logic [EW-1:0]            eor;
    logic [EW-1:0]            esh [6];
    logic [EDGE_W-1:0]        eabs [6];
    logic [NORM_W-1:0]        nmag [3];
    logic [NORM_W-1:0]        nor_m;
    logic [NORM_W-1:0]        nsh [3];
    logic [NP_W-1:0]          nabs [3];
    logic signed [SQ_W-1:0]   sqs [3];
    logic [SUM_W-2:0]         s_mag;

    // the whole front moves together unless the last face cannot enter the queue
    assign adv        = !(vld_reg[STAGES-1] && q_full);
    assign face.ready = adv;
    assign q_push     = adv && vld_reg[STAGES-1];
    assign vld_next   = {vld_reg[STAGES-2:0], face.valid};

    always_comb
    begin
        // edges, exact
        e1_next[0] = $signed({face.b_x[COORD_WIDTH-1], face.b_x})
                   - $signed({face.a_x[COORD_WIDTH-1], face.a_x});
        e1_next[1] = $signed({face.b_y[COORD_WIDTH-1], face.b_y})
                   - $signed({face.a_y[COORD_WIDTH-1], face.a_y});
        e1_next[2] = $signed({face.b_z[COORD_WIDTH-1], face.b_z})
                   - $signed({face.a_z[COORD_WIDTH-1], face.a_z});
        e1_next[3] = $signed({face.c_x[COORD_WIDTH-1], face.c_x})
                   - $signed({face.a_x[COORD_WIDTH-1], face.a_x});
        e1_next[4] = $signed({face.c_y[COORD_WIDTH-1], face.c_y})
                   - $signed({face.a_y[COORD_WIDTH-1], face.a_y});
        e1_next[5] = $signed({face.c_z[COORD_WIDTH-1], face.c_z})
                   - $signed({face.a_z[COORD_WIDTH-1], face.a_z});

        // common edge shift from the leading one of all magnitudes
        eor = '0;
        for (int i = 0; i < 6; i++)
        begin
            emag[i]    = emag_f(e1_reg[i]);
            eor        = eor | emag[i];
            e2_next[i] = e1_reg[i];
        end
        ek_next = '0;
        for (int i = 0; i < EW; i++)
        begin
            if (eor[i] && (i + 1 > ESIG_BITS))
                ek_next = EKW'(i + 1 - ESIG_BITS);
        end

        // shrink magnitudes, keep sign
        for (int i = 0; i < 6; i++)
        begin
            esh[i]     = emag_f(e2_reg[i]) >> ek_reg;
            eabs[i]    = EDGE_W'(esh[i]);
            e3_next[i] = e2_reg[i][EW-1] ? $signed(-eabs[i]) : $signed(eabs[i]);
        end

        // cross product terms
        p4_next[0] = e3_reg[1] * e3_reg[5];
        p4_next[1] = e3_reg[2] * e3_reg[4];
        p4_next[2] = e3_reg[2] * e3_reg[3];
        p4_next[3] = e3_reg[0] * e3_reg[5];
        p4_next[4] = e3_reg[0] * e3_reg[4];
        p4_next[5] = e3_reg[1] * e3_reg[3];

        n5_next[0] = p4_reg[0] - p4_reg[1];
        n5_next[1] = p4_reg[2] - p4_reg[3];
        n5_next[2] = p4_reg[4] - p4_reg[5];
        z5_next    = (n5_next[0] == '0) && (n5_next[1] == '0) && (n5_next[2] == '0);

        // common normal shift
        nor_m = '0;
        for (int i = 0; i < 3; i++)
        begin
            nmag[i]    = nmag_f(n5_reg[i]);
            nor_m      = nor_m | nmag[i];
            n6_next[i] = n5_reg[i];
        end
        nk_next = '0;
        for (int i = 0; i < NORM_W; i++)
        begin
            if (nor_m[i] && (i + 1 > NSIG_BITS))
                nk_next = NKW'(i + 1 - NSIG_BITS);
        end
        z6_next = z5_reg;

        for (int i = 0; i < 3; i++)
        begin
            nsh[i]     = nmag_f(n6_reg[i]) >> nk_reg;
            nabs[i]    = NP_W'(nsh[i]);
            n7_next[i] = n6_reg[i][NORM_W-1] ? $signed(-nabs[i]) : $signed(nabs[i]);
        end
        z7_next = z6_reg;

        // sum and squares
        s8_next = SUM_W'(n7_reg[0]) + SUM_W'(n7_reg[1]) + SUM_W'(n7_reg[2]);
        for (int i = 0; i < 3; i++)
        begin
            sqs[i]      = n7_reg[i] * n7_reg[i];
            sq8_next[i] = $unsigned(sqs[i]);
        end
        z8_next = z7_reg;

        // classify: lit only when the light meets the front face
        s_mag     = s8_reg[SUM_W-2:0];
        q9_next   = sq8_reg[0] + sq8_reg[1] + sq8_reg[2];
        ssq9_next = s_mag * s_mag;
        lit9_next = !s8_reg[SUM_W-1] && (s8_reg != '0);
        z9_next   = z8_reg;

        t10_next   = {2'b00, q9_reg} + {1'b0, q9_reg, 1'b0};
        ssq10_next = ssq9_reg;
        lit10_next = lit9_reg;
        z10_next   = z9_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e1_reg    <= e1_next;
            e2_reg    <= e2_next;
            ek_reg    <= ek_next;
            e3_reg    <= e3_next;
            p4_reg    <= p4_next;
            n5_reg    <= n5_next;
            z5_reg    <= z5_next;
            n6_reg    <= n6_next;
            nk_reg    <= nk_next;
            z6_reg    <= z6_next;
            n7_reg    <= n7_next;
            z7_reg    <= z7_next;
            s8_reg    <= s8_next;
            sq8_reg   <= sq8_next;
            z8_reg    <= z8_next;
            q9_reg    <= q9_next;
            ssq9_reg  <= ssq9_next;
            lit9_reg  <= lit9_next;
            z9_reg    <= z9_next;
            t10_reg   <= t10_next;
            ssq10_reg <= ssq10_next;
            lit10_reg <= lit10_next;
            z10_reg   <= z10_next;
        end
    end

    assign q_item.s_sq   = ssq10_reg;
    assign q_item.t3q    = t10_reg;
    assign q_item.zero_n = z10_reg;
    assign q_item.lit    = lit10_reg;

endmodule

### rtl/core/ffsi_queue.sv
module ffsi_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  ffsi_pkg::front_item_t push_item,
    output logic                  full,
    input  logic                  pop,
    output ffsi_pkg::front_item_t pop_item,
    output logic                  empty
);
    import ffsi_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    front_item_t      mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign full     = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule

### rtl/core/ffsi_back.sv
module ffsi_back #(
    parameter int INTENSITY_FRAC_BITS = 15
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_empty,
    input  ffsi_pkg::front_item_t       q_item,
    output logic                        q_pop,
    input  logic [ffsi_pkg::OUT_W-1:0]  ambient_floor,
    ffsi_shade_if.source                shade
);
    import ffsi_pkg::*;

    localparam int F  = INTENSITY_FRAC_BITS;
    localparam int ND = 2 * F + 1;
    localparam int QW = 2 * F + 1;
    localparam int NS = F + 1;
    localparam int RW = 2 * NS;
    localparam int SW = F + 4;
    localparam int LW = (F + 1 > OUT_W) ? F + 1 : OUT_W;

    logic adv;

    // divide stages: quotient of s^2 * 2^2F by 3q, one bit a stage
    logic [T_W-1:0] d_rem_reg [ND+1], d_rem_next [ND+1];
    logic [QW-1:0]  d_quo_reg [ND+1], d_quo_next [ND+1];
    logic [T_W-1:0] d_t_reg   [ND+1], d_t_next   [ND+1];
    logic           d_lit_reg [ND+1], d_lit_next [ND+1];
    logic           d_z_reg   [ND+1], d_z_next   [ND+1];
    logic           d_vld_reg [ND+1], d_vld_next [ND+1];
    logic           d_low_reg, d_low_next;

    // root stages: floor of the square root, one bit a stage
    logic [RW-1:0] r_rad  [NS+1];
    logic [F:0]    r_root [NS+1];
    logic [SW-1:0] r_rem  [NS+1];
    logic          r_lit  [NS+1];
    logic          r_z    [NS+1];
    logic          r_vld  [NS+1];
    logic [RW-1:0] r_rad_reg  [1:NS], r_rad_next  [1:NS];
    logic [F:0]    r_root_reg [1:NS], r_root_next [1:NS];
    logic [SW-1:0] r_rem_reg  [1:NS], r_rem_next  [1:NS];
    logic          r_lit_reg  [1:NS], r_lit_next  [1:NS];
    logic          r_z_reg    [1:NS], r_z_next    [1:NS];
    logic          r_vld_reg  [1:NS], r_vld_next  [1:NS];

    logic             out_vld_reg, out_vld_next;
    logic [OUT_W-1:0] out_int_reg, out_int_next;
    logic             out_deg_reg, out_deg_next;

    logic [F:0]    lam;
    logic [LW-1:0] lam_x, flo_x, best;

    assign adv   = !out_vld_reg || shade.ready;
    assign q_pop = adv && !q_empty;

    always_comb
    begin
        d_vld_next[0] = q_pop;
        d_rem_next[0] = T_W'(q_item.s_sq >> 1);
        d_low_next    = q_item.s_sq[0];
        d_quo_next[0] = '0;
        d_t_next[0]   = q_item.t3q;
        d_lit_next[0] = q_item.lit;
        d_z_next[0]   = q_item.zero_n;
    end

    for (genvar j = 0; j < ND; j++)
    begin : g_div
        logic         bit_in;
        logic [T_W:0] sh, diff;
        logic         ge;

        always_comb
        begin
            bit_in = (j == 0) ? d_low_reg : 1'b0;
            sh     = {d_rem_reg[j], bit_in};
            diff   = sh - {1'b0, d_t_reg[j]};
            ge     = (sh >= {1'b0, d_t_reg[j]});
            d_rem_next[j+1] = ge ? diff[T_W-1:0] : sh[T_W-1:0];
            d_quo_next[j+1] = {d_quo_reg[j][QW-2:0], ge};
            d_t_next[j+1]   = d_t_reg[j];
            d_lit_next[j+1] = d_lit_reg[j];
            d_z_next[j+1]   = d_z_reg[j];
            d_vld_next[j+1] = d_vld_reg[j];
        end
    end

    assign r_rad[0]  = RW'(d_quo_reg[ND]);
    assign r_root[0] = '0;
    assign r_rem[0]  = '0;
    assign r_lit[0]  = d_lit_reg[ND];
    assign r_z[0]    = d_z_reg[ND];
    assign r_vld[0]  = d_vld_reg[ND];

    for (genvar i = 0; i < NS; i++)
    begin : g_root
        logic [1:0]    pair;
        logic [SW+1:0] remsh_w;
        logic [SW-1:0] remsh, trial;
        logic          ge;

        assign r_rad[i+1]  = r_rad_reg[i+1];
        assign r_root[i+1] = r_root_reg[i+1];
        assign r_rem[i+1]  = r_rem_reg[i+1];
        assign r_lit[i+1]  = r_lit_reg[i+1];
        assign r_z[i+1]    = r_z_reg[i+1];
        assign r_vld[i+1]  = r_vld_reg[i+1];

        always_comb
        begin
            pair    = r_rad[i][RW-1-2*i -: 2];
            remsh_w = {r_rem[i], pair};
            remsh   = remsh_w[SW-1:0];
            trial   = SW'({r_root[i], 2'b01});
            ge      = (remsh >= trial);
            r_rem_next[i+1]  = ge ? remsh - trial : remsh;
            r_root_next[i+1] = {r_root[i][F-1:0], ge};
            r_rad_next[i+1]  = r_rad[i];
            r_lit_next[i+1]  = r_lit[i];
            r_z_next[i+1]    = r_z[i];
            r_vld_next[i+1]  = r_vld[i];
        end
    end

    // floor and saturation
    always_comb
    begin
        lam   = r_lit[NS] ? r_root[NS] : '0;
        lam_x = LW'(lam);
        flo_x = LW'(ambient_floor);
        best  = (lam_x > flo_x) ? lam_x : flo_x;
        out_int_next = (best > LW'(OUT_MAX)) ? OUT_MAX : best[OUT_W-1:0];
        out_deg_next = r_z[NS];
        out_vld_next = r_vld[NS];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_vld_reg   <= '{default: 1'b0};
            r_vld_reg   <= '{default: 1'b0};
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            d_vld_reg   <= d_vld_next;
            r_vld_reg   <= r_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_rem_reg   <= d_rem_next;
            d_quo_reg   <= d_quo_next;
            d_t_reg     <= d_t_next;
            d_lit_reg   <= d_lit_next;
            d_z_reg     <= d_z_next;
            d_low_reg   <= d_low_next;
            r_rad_reg   <= r_rad_next;
            r_root_reg  <= r_root_next;
            r_rem_reg   <= r_rem_next;
            r_lit_reg   <= r_lit_next;
            r_z_reg     <= r_z_next;
            out_int_reg <= out_int_next;
            out_deg_reg <= out_deg_next;
        end
    end

    assign shade.valid      = out_vld_reg;
    assign shade.intensity  = out_int_reg;
    assign shade.degenerate = out_deg_reg;

endmodule

### tb/sv/face_flat_shading_intensity_tb.sv
`timescale 1ns / 100ps

module face_flat_shading_intensity_tb;
    import ffsi_pkg::*;

    // vertex triple for one face, as driven on the face channel
    typedef struct {
        logic signed [15:0] v [9];
    } face_t;

    typedef struct {
        logic [15:0] intensity;
        logic        degenerate;
    } shade_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;

    ffsi_tri_if #(.COORD_WIDTH(16)) face ();
    ffsi_shade_if shade ();

    face_flat_shading_intensity #(
        .COORD_WIDTH(16),
        .INTENSITY_FRAC_BITS(15)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .face(face),
        .shade(shade)
    );

    // faces waiting to be driven and shades waiting to come out
    face_t  pending_faces[$];
    shade_t expected_shades[$];

    // testbench copy of the ambient floor register
    logic [15:0] floor_model;

    int  errors;
    int  shades_seen;
    int  degenerate_seen;
    int  faces_sent;
    longint cycle_count;
    bit  send_pause;      // sender holds off while set
    int  hold_cycles;     // long receiver hold-off, counted by the receiver
    bit  long_hold_req;

    localparam longint CYCLE_LIMIT = 400000;
    localparam int     DRAIN_CYCLES = 120;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // signed magnitude truncation by k, sign kept
    function automatic longint shrink_mag(longint x, int k);
        longint m;
        m = (x < 0) ? -x : x;
        m = m >>> k;
        return (x < 0) ? -m : m;
    endfunction

    // lambert intensity of one face under the current floor
    function automatic shade_t shade_of_face(face_t f);
        shade_t r;
        longint e [6];
        longint n [3];
        longint mx, s;
        int k;
        logic [127:0] t, rhs, cand, lam;
        e[0] = longint'(f.v[3]) - f.v[0];
        e[1] = longint'(f.v[4]) - f.v[1];
        e[2] = longint'(f.v[5]) - f.v[2];
        e[3] = longint'(f.v[6]) - f.v[0];
        e[4] = longint'(f.v[7]) - f.v[1];
        e[5] = longint'(f.v[8]) - f.v[2];
        // 16-bit coordinates keep edges below 2^17, no edge shrink needed
        n[0] = e[1] * e[5] - e[2] * e[4];
        n[1] = e[2] * e[3] - e[0] * e[5];
        n[2] = e[0] * e[4] - e[1] * e[3];
        if (n[0] == 0 && n[1] == 0 && n[2] == 0)
        begin
            r.intensity  = floor_model;
            r.degenerate = 1'b1;
            return r;
        end
        mx = 0;
        for (int i = 0; i < 3; i++)
        begin
            if ((n[i] < 0 ? -n[i] : n[i]) > mx)
                mx = (n[i] < 0) ? -n[i] : n[i];
        end
        k = 0;
        while ((mx >>> k) >= (64'sd1 <<< 20))
            k++;
        for (int i = 0; i < 3; i++)
            n[i] = shrink_mag(n[i], k);
        s = n[0] + n[1] + n[2];
        lam = '0;
        if (s > 0)
        begin
            t = 128'(3) * (128'(n[0] * n[0]) + 128'(n[1] * n[1]) + 128'(n[2] * n[2]));
            rhs = (128'(s) * 128'(s)) << 30;
            for (int b = 15; b >= 0; b--)
            begin
                cand = lam | (128'd1 << b);
                if (cand <= 128'd32768 && cand * cand * t <= rhs)
                    lam = cand;
            end
        end
        if (lam < {112'd0, floor_model})
            lam = {112'd0, floor_model};
        r.intensity  = (lam > 128'hFFFF) ? 16'hFFFF : lam[15:0];
        r.degenerate = 1'b0;
        return r;
    endfunction

    function automatic face_t face_from(int ax, int ay, int az, int bx, int by, int bz,
                                        int cx, int cy, int cz);
        face_t f;
        f.v[0] = 16'(ax); f.v[1] = 16'(ay); f.v[2] = 16'(az);
        f.v[3] = 16'(bx); f.v[4] = 16'(by); f.v[5] = 16'(bz);
        f.v[6] = 16'(cx); f.v[7] = 16'(cy); f.v[8] = 16'(cz);
        return f;
    endfunction

    function automatic face_t random_face();
        face_t f;
        int mode;
        mode = $urandom_range(0, 9);
        for (int i = 0; i < 9; i++)
            f.v[i] = 16'($urandom);
        if (mode == 0)
        begin
            // collinear: c = a + 2*(b - a) on a small scale
            for (int i = 0; i < 3; i++)
            begin
                f.v[i]     = 16'($urandom_range(0, 2000) - 1000);
                f.v[3 + i] = 16'(f.v[i] + $urandom_range(0, 200) - 100);
                f.v[6 + i] = 16'(f.v[i] + 2 * (f.v[3 + i] - f.v[i]));
            end
        end
        else if (mode == 1)
        begin
            // tiny triangles, often degenerate or heavily quantized
            for (int i = 0; i < 9; i++)
                f.v[i] = 16'($urandom_range(0, 4) - 2);
        end
        else if (mode == 2)
        begin
            // coordinates at the rails
            for (int i = 0; i < 9; i++)
                f.v[i] = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        end
        return f;
    endfunction

    // sender: bursts and gaps, fed from the pending queue
    int burst_left;
    int gap_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            face.valid <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else
        begin
            logic fire;
            fire = face.valid && face.ready;
            if (fire)
            begin
                expected_shades.push_back(shade_of_face(pending_faces.pop_front()));
                faces_sent++;
            end
            if (!face.valid || fire)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    face.valid <= 1'b0;
                end
                else if (pending_faces.size() > 0 && !send_pause)
                begin
                    face.valid <= 1'b1;
                    face.a_x <= pending_faces[0].v[0];
                    face.a_y <= pending_faces[0].v[1];
                    face.a_z <= pending_faces[0].v[2];
                    face.b_x <= pending_faces[0].v[3];
                    face.b_y <= pending_faces[0].v[4];
                    face.b_z <= pending_faces[0].v[5];
                    face.c_x <= pending_faces[0].v[6];
                    face.c_y <= pending_faces[0].v[7];
                    face.c_z <= pending_faces[0].v[8];
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    face.valid <= 1'b0;
            end
        end
    end

    // receiver: own stall pattern plus one long hold-off
    int stall_phase;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shade.ready <= 1'b0;
            stall_phase <= 0;
            hold_cycles <= 0;
        end
        else
        begin
            if (shade.valid && shade.ready)
            begin
                shade_t want;
                if (expected_shades.size() == 0)
                begin
                    $display("%0t: unexpected shade item intensity=%0d degenerate=%0b",
                             $time, shade.intensity, shade.degenerate);
                    errors++;
                end
                else
                begin
                    want = expected_shades.pop_front();
                    if (shade.intensity !== want.intensity)
                    begin
                        $display("%0t: intensity expected %0d actual %0d",
                                 $time, want.intensity, shade.intensity);
                        errors++;
                    end
                    if (shade.degenerate !== want.degenerate)
                    begin
                        $display("%0t: degenerate expected %0b actual %0b",
                                 $time, want.degenerate, shade.degenerate);
                        errors++;
                    end
                    if (want.degenerate)
                        degenerate_seen++;
                end
                shades_seen++;
            end
            stall_phase <= stall_phase + 1;
            if (long_hold_req && hold_cycles == 0)
                hold_cycles <= 300;
            if (hold_cycles > 0)
            begin
                hold_cycles <= hold_cycles - 1;
                shade.ready <= 1'b0;
            end
            else if (stall_phase[9])
                // quiet stretch, always ready
                shade.ready <= 1'b1;
            else
                shade.ready <= (stall_phase % 7 != 3) && ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_faces.size() > 0 || face.valid || expected_shades.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // floor write while the block is idle
    task automatic write_floor(logic [15:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        floor_model = value;
    endtask

    initial
    begin
        logic [15:0] floors [5];
        errors = 0; shades_seen = 0; degenerate_seen = 0; faces_sent = 0;
        cycle_count = 0;
        send_pause = 0; long_hold_req = 0;
        floor_model = FLOOR_RESET;
        cfg_wr_en = 1'b0; cfg_wr_data = '0;
        face.valid = 1'b0;
        face.a_x = '0; face.a_y = '0; face.a_z = '0;
        face.b_x = '0; face.b_y = '0; face.b_z = '0;
        face.c_x = '0; face.c_y = '0; face.c_z = '0;
        shade.ready = 1'b0;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed faces under the reset floor
        pending_faces.push_back(face_from(0, 0, 0, 16384, 0, 0, 0, 16384, 0));
        pending_faces.push_back(face_from(0, 0, 0, 0, 16384, 0, 16384, 0, 0));
        pending_faces.push_back(face_from(16384, 0, 0, 0, 16384, 0, 0, 0, 16384));
        pending_faces.push_back(face_from(0, 0, 0, 1, 1, 1, 2, 2, 2));
        pending_faces.push_back(face_from(5, 5, 5, 5, 5, 5, 5, 5, 5));
        pending_faces.push_back(face_from(0, 0, 0, 1, -1, 0, 0, 1, -1));
        pending_faces.push_back(face_from(-32768, -32768, -32768, 32767, -32768, -32768,
                                          -32768, 32767, -32768));
        pending_faces.push_back(face_from(32767, 32767, 32767, -32768, 32767, 32767,
                                          32767, -32768, 32767));
        pending_faces.push_back(face_from(-32768, 0, 0, 32767, 0, 0, 0, 32767, 32767));
        pending_faces.push_back(face_from(0, 0, 0, 0, 0, 1, 0, 1, 0));
        pending_faces.push_back(face_from(0, 0, 0, 1, 0, 0, 0, 0, 1));
        pending_faces.push_back(face_from(0, 0, 0, 32767, -32768, 0, 0, 32767, -32768));
        pending_faces.push_back(face_from(-1, -1, -1, -1, -1, -1, 0, 0, 0));
        wait_drained();

        // floors: extremes, mid, above range, then a random floor in the last pass
        floors[0] = 16'd0;
        floors[1] = 16'd32768;
        floors[2] = 16'hFFFF;
        floors[3] = 16'd16000;
        floors[4] = 16'd328;
        for (int p = 0; p < 5; p++)
        begin
            write_floor(p == 4 ? 16'($urandom_range(0, 32768)) : floors[p]);
            pending_faces.push_back(face_from(0, 0, 0, 16384, 0, 0, 0, 16384, 0));
            pending_faces.push_back(face_from(0, 0, 0, 1, 1, 1, 2, 2, 2));
            pending_faces.push_back(face_from(0, 0, 0, 0, 16384, 0, 16384, 0, 0));
            for (int i = 0; i < 220; i++)
                pending_faces.push_back(random_face());
            if (p == 1)
            begin
                // long receiver hold-off while faces keep coming, fills the block
                long_hold_req = 1;
                wait (hold_cycles > 0);
                long_hold_req = 0;
            end
            if (p == 2)
            begin
                // sender pauses until everything outstanding has come out
                while (pending_faces.size() > 100)
                    @(posedge clk);
                send_pause = 1;
                while (face.valid || expected_shades.size() > 0)
                    @(posedge clk);
                send_pause = 0;
            end
            wait_drained();
        end

        $display("faces sent %0d, shades checked %0d, degenerate %0d", faces_sent,
                 shades_seen, degenerate_seen);
        $display("floors covered: zero, full scale, above range, mid and random");
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

### sim.f
rtl/core/ffsi_pkg.sv
rtl/core/ffsi_if.sv
rtl/core/ffsi_front.sv
rtl/core/ffsi_queue.sv
rtl/core/ffsi_back.sv
rtl/core/face_flat_shading_intensity.sv
tb/sv/face_flat_shading_intensity_tb.sv
